FILE: hdl/ialu_pkg.sv
// Package for the three-width integer ALU: opcodes, width codes, stage payload types.
// No dependencies.
package ialu_pkg;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MOD = 4'd4,
    OP_OR  = 4'd5,
    OP_AND = 4'd6,
    OP_XOR = 4'd7,
    OP_SHL = 4'd8
  } op_e;

  localparam logic [1:0] WSEL_8  = 2'd0;
  localparam logic [1:0] WSEL_16 = 2'd1;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned QBITS  = 4;
  localparam int unsigned DIV_STAGES = DATA_W / QBITS;

  // Input transaction; opcode is kept raw since undefined codes are legal.
  typedef struct packed {
    logic [3:0]  opcode;
    logic [1:0]  width_select;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
  } alu_req_t;

  // Output transaction.
  typedef struct packed {
    logic [31:0] result;
  } alu_res_t;

  // Divider stage state; it travels with the item.
  typedef struct packed {
    logic [3:0]  opcode;
    logic [1:0]  wsel;
    logic [31:0] a_ext;     // sign-extended operand a
    logic [31:0] b_ext;     // sign-extended operand b
    logic [31:0] simple;    // result of the simple ops computed in stage 0
    logic [31:0] rem;       // partial remainder (magnitude)
    logic [31:0] quo;       // quotient bits / shifted dividend
    logic [31:0] dvs;       // divisor magnitude
  } div_st_t;

  function automatic logic [31:0] sext_w(input logic [31:0] v, input logic [1:0] wsel);
    logic [31:0] r;
    case (wsel)
      WSEL_8:  r = {{24{v[7]}}, v[7:0]};
      WSEL_16: r = {{16{v[15]}}, v[15:0]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/ialu_stream_if.sv
// Valid/ready stream interface with parameterized payload.
// Depends on nothing.
interface ialu_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/ialu_div_step.sv
// One radix-16 restoring division stage (four quotient bits), registered.
// Depends on ialu_pkg.
module ialu_div_step (
  input  logic                clk_i,
  input  logic                en_i,
  input  ialu_pkg::div_st_t   st_i,
  output ialu_pkg::div_st_t   st_o
);
  ialu_pkg::div_st_t st_d, st_q;
  logic [32:0] r;

  always_comb begin
    st_d = st_i;
    r = {1'b0, st_i.rem};
    for (int i = 0; i < ialu_pkg::QBITS; i++) begin
      r = {r[31:0], st_d.quo[31]};
      st_d.quo = {st_d.quo[30:0], 1'b0};
      if (r >= {1'b0, st_d.dvs}) begin
        r = r - {1'b0, st_d.dvs};
        st_d.quo[0] = 1'b1;
      end
    end
    st_d.rem = r[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) st_q <= st_d;
  end

  assign st_o = st_q;
endmodule

FILE: hdl/integer_alu_three_widths_core.sv
// Top level of the three-width integer ALU.
// Depends on ialu_pkg, ialu_stream_if, ialu_div_step.
//
// Fully pipelined ALU: one transaction accepted per cycle while the output does not
// stall; a result passes through the input register, eight radix-16 divider
// stages that all ops pass through, a multiply stage and a result register.
// The whole pipe advances together; a stall on the output holds every stage.
// There is no skid register: while a result waits, in_i.ready follows out_o.ready.
module integer_alu_three_widths_core (
  input  logic clk_i,
  input  logic rst_ni,
  ialu_stream_if.sink   in_i,
  ialu_stream_if.source out_o
);
  localparam int unsigned NST = ialu_pkg::DIV_STAGES + 3;

  logic [NST-1:0] vld_q;
  logic           adv;

  assign adv = !vld_q[NST-1] || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[NST-2:0], in_i.valid};
  end

  // Stage 0: extend operands, simple ops, setup of the unsigned division.
  ialu_pkg::div_st_t s0_d, s0_q;
  logic [31:0] a_x, b_x, w, na, nb;
  logic [5:0]  wbits;
  always_comb begin
    a_x = ialu_pkg::sext_w(in_i.data.operand_a, in_i.data.width_select);
    b_x = ialu_pkg::sext_w(in_i.data.operand_b, in_i.data.width_select);
    case (in_i.data.width_select)
      ialu_pkg::WSEL_8:  wbits = 6'd8;
      ialu_pkg::WSEL_16: wbits = 6'd16;
      default:           wbits = 6'd32;
    endcase
    na = a_x[31] ? -a_x : a_x;
    nb = b_x[31] ? -b_x : b_x;
    case (in_i.data.opcode)
      ialu_pkg::OP_ADD: w = a_x + b_x;
      ialu_pkg::OP_SUB: w = a_x - b_x;
      ialu_pkg::OP_OR:  w = a_x | b_x;
      ialu_pkg::OP_AND: w = a_x & b_x;
      ialu_pkg::OP_XOR: w = a_x ^ b_x;
      ialu_pkg::OP_SHL: w = (b_x[31] || (b_x >= {26'd0, wbits})) ? 32'd0 : (a_x << b_x[4:0]);
      default:          w = 32'd0;
    endcase
    s0_d.opcode = in_i.data.opcode;
    s0_d.wsel   = in_i.data.width_select;
    s0_d.a_ext  = a_x;
    s0_d.b_ext  = b_x;
    s0_d.simple = w;
    s0_d.rem    = 32'd0;
    s0_d.quo    = na;
    s0_d.dvs    = nb;
  end

  always_ff @(posedge clk_i) begin
    if (adv) s0_q <= s0_d;
  end

  ialu_pkg::div_st_t chain [ialu_pkg::DIV_STAGES+1];
  assign chain[0] = s0_q;
  for (genvar g = 0; g < ialu_pkg::DIV_STAGES; g++) begin : g_div
    ialu_div_step u_step (.clk_i, .en_i(adv), .st_i(chain[g]), .st_o(chain[g+1]));
  end

  // Multiply stage, divide/mod sign fixups.
  ialu_pkg::div_st_t d_s;
  ialu_pkg::div_st_t fin_d;
  logic [31:0] m_d, m_q, q_s, r_s, sel_d, maxv;
  always_comb begin
    d_s = chain[ialu_pkg::DIV_STAGES];
    m_d = d_s.a_ext * d_s.b_ext;
    case (d_s.wsel)
      ialu_pkg::WSEL_8:  maxv = 32'h0000_007F;
      ialu_pkg::WSEL_16: maxv = 32'h0000_7FFF;
      default:           maxv = 32'h7FFF_FFFF;
    endcase
    q_s = (d_s.a_ext[31] ^ d_s.b_ext[31]) ? -d_s.quo : d_s.quo;
    r_s = d_s.a_ext[31] ? -d_s.rem : d_s.rem;
    case (d_s.opcode)
      ialu_pkg::OP_DIV: begin
        if (d_s.b_ext == 32'd0) begin
          if (d_s.a_ext == 32'd0) sel_d = 32'd0;
          else if (d_s.a_ext[31]) sel_d = ~maxv;
          else sel_d = maxv;
        end else sel_d = q_s;
      end
      ialu_pkg::OP_MOD: sel_d = (d_s.b_ext == 32'd0) ? d_s.a_ext : r_s;
      default:          sel_d = d_s.simple;
    endcase
    fin_d = d_s;
    fin_d.simple = sel_d;
  end

  ialu_pkg::div_st_t fin_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_q <= m_d;
      fin_q <= fin_d;
    end
  end

  logic [31:0] res_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= ialu_pkg::sext_w(
        (fin_q.opcode == ialu_pkg::OP_MUL) ? m_q : fin_q.simple, fin_q.wsel);
    end
  end

  assign out_o.valid = vld_q[NST-1];
  assign out_o.data.result = res_q;
endmodule

FILE: hdl/ialu_checker.sv
// Port-level checker for the integer ALU, bound to the top level.
// Depends on integer_alu_three_widths_core ports.
module ialu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_result_i
);
  // Held result is not replaced while stalled.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_result_i))
    else $error("result changed under stall");
  // Input side stalls only when output stalls.
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output stall");
  // Reset clears output valid.
  a_rst: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("valid after reset");
endmodule

bind integer_alu_three_widths_core ialu_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid_i(in_i.valid), .in_ready_i(in_i.ready),
  .out_valid_i(out_o.valid), .out_ready_i(out_o.ready),
  .out_result_i(out_o.data.result)
);
